// ----- rtl/imu_to_arm_position_mapper_core_defines.svh -----
// imu_to_arm_position_mapper_core_defines.svh
// assertion macros for the imu to arm position mapper checker
// no dependencies
`ifndef IMU_TO_ARM_POSITION_MAPPER_CORE_DEFINES_SVH
`define IMU_TO_ARM_POSITION_MAPPER_CORE_DEFINES_SVH

// clocked assertion with reset disable
`define IMAP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("imap assertion failed");

// a signal holds its value in the cycle after a condition
`define IMAP_ASSERT_STABLE(lbl, clk, rstn, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> $stable(sig)) \
    else $error("imap stability assertion failed");

`endif

// ----- rtl/imap_pkg.sv -----
// imap_pkg.sv
// types, constants and reciprocal factors of the imu to arm position mapper
// no dependencies
`timescale 1ns / 1ps

package imap_pkg;

  // field types
  typedef logic signed [15:0] sample_t;
  typedef logic [7:0]         period_t;
  typedef logic [7:0]         rotation_t;
  typedef logic [8:0]         stretch_t;
  typedef logic [7:0]         height_t;

  // samples per result and the counter that reaches it
  localparam int unsigned Decimation = 5;
  localparam int unsigned CountW     = $clog2(Decimation + 1);
  typedef logic [CountW-1:0] count_t;
  localparam count_t CountLast = CountW'(Decimation);

  // configuration reset
  localparam period_t PeriodReset = 8'd30;

  // angle in q8.10 degrees
  localparam int unsigned AngleW = 18;
  typedef logic [AngleW-1:0] angle_t;
  localparam angle_t AngleReset = 18'd92160;
  localparam angle_t AngleMax   = 18'd184320;

  // gyro step applies only when |rate * period| reaches one degree
  localparam logic [23:0] StepMin = 24'd1000;

  // floor(z / 125) = (z * Recip125) >> 32 for z below 2**25
  localparam logic [25:0] Recip125  = 26'd34359739;
  // floor(z / 33) = (z * Recip33) >> 19 for z below 2**15
  localparam logic [13:0] Recip33   = 14'd15888;
  // floor(z / 6) = (z * Recip6) >> 14 for z below 2**12
  localparam logic [11:0] Recip6    = 12'd2731;

  // stretch mapping limits
  localparam stretch_t StretchHi  = 9'd300;
  localparam stretch_t StretchLo  = 9'd10;
  localparam stretch_t StretchCut = 9'd290;
  localparam sample_t  AxFar      = -16'sd960;

  // height mapping limits
  localparam height_t HeightHi  = 8'd150;
  localparam height_t HeightLo  = 8'd10;
  localparam logic [8:0] HeightCut = 9'd140;
  localparam sample_t AyFar     = 16'sd1023;

  // accumulator saturation
  localparam logic [10:0] StretchSumMax = 11'd2047;
  localparam logic [9:0]  HeightSumMax  = 10'd1023;

endpackage

// ----- rtl/imap_channels.sv -----
// imap_channels.sv
// valid/ready channel interfaces for sample requests, results and configuration
// depends on imap_pkg
`timescale 1ns / 1ps

// sample request channel
interface imap_req_if;
  logic               valid;
  logic               ready;
  imap_pkg::sample_t  accel_x;
  imap_pkg::sample_t  accel_y;
  imap_pkg::sample_t  gyro_z;
  modport source (output valid, output accel_x, output accel_y, output gyro_z, input ready);
  modport sink   (input valid, input accel_x, input accel_y, input gyro_z, output ready);
endinterface

// result channel
interface imap_res_if;
  logic                valid;
  logic                ready;
  imap_pkg::rotation_t rotation;
  imap_pkg::stretch_t  stretch;
  imap_pkg::height_t   height;
  modport source (output valid, output rotation, output stretch, output height, input ready);
  modport sink   (input valid, input rotation, input stretch, input height, output ready);
endinterface

// configuration write channel
interface imap_cfg_if;
  logic              valid;
  logic              ready;
  imap_pkg::period_t sample_period_ms;
  modport source (output valid, output sample_period_ms, input ready);
  modport sink   (input valid, input sample_period_ms, output ready);
endinterface

// ----- rtl/imu_to_arm_position_mapper_core.sv -----
// Maps IMU samples to arm rotation, stretch and height. One sample request is taken
// per clock cycle unless a stalled result backs up the stages; a sample goes through an
// input register, a multiply stage (gyro rate times period, accel reciprocal scaling), a
// divide-by-125 reciprocal stage and the update stage that owns the angle, the two
// accumulators and the sample counter and loads the output register. Every fifth sample
// yields one result; the others only update state. The feedback through the update
// stage sets the rate of one sample per cycle. A waiting result does not stop requests
// until the stages behind it are full. The user must write the configuration register
// only while no sample is in flight; the block itself does not enforce it.
// imu_to_arm_position_mapper_core.sv
// depends on imap_pkg and imap_channels
`timescale 1ns / 1ps

module imu_to_arm_position_mapper_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  imap_req_if.sink   req_i,
  imap_res_if.source res_o,
  imap_cfg_if.sink   cfg_i
);

  // configuration
  imap_pkg::period_t period_q;

  // stage a: input register
  logic              a_valid_q;
  imap_pkg::sample_t a_ax_q, a_ay_q, a_gz_q;

  // stage b: products
  logic        b_valid_q;
  logic [23:0] b_mag_q;
  logic        b_neg_q;
  logic        b_x_top_q, b_x_far_q;
  logic [8:0]  b_qx_q;
  logic        b_y_top_q, b_y_far_q;
  logic [8:0]  b_qy_q;

  // stage c: step and mapped positions
  logic               c_valid_q;
  logic [23:0]        c_step_q;
  logic               c_neg_q;
  logic               c_en_q;
  imap_pkg::stretch_t c_stretch_q;
  imap_pkg::height_t  c_height_q;

  // state
  imap_pkg::angle_t angle_q, angle_d;
  logic [10:0]      ssum_q, ssum_d;
  logic [9:0]       hsum_q, hsum_d;
  imap_pkg::count_t count_q, count_d;

  // result register
  logic                res_valid_q;
  imap_pkg::rotation_t res_rot_q;
  imap_pkg::stretch_t  res_str_q;
  imap_pkg::height_t   res_hgt_q;

  // flow control
  logic emit, out_free, fire_d, adv_b, adv_a, in_ready, acc;

  assign out_free = !res_valid_q || res_o.ready;
  assign fire_d   = c_valid_q && (!emit || out_free);
  assign adv_b    = b_valid_q && (!c_valid_q || fire_d);
  assign adv_a    = a_valid_q && (!b_valid_q || adv_b);
  assign in_ready = !a_valid_q || adv_a;
  assign acc      = req_i.valid && in_ready;

  assign req_i.ready    = in_ready;
  assign cfg_i.ready    = 1'b1;
  assign res_o.valid    = res_valid_q;
  assign res_o.rotation = res_rot_q;
  assign res_o.stretch  = res_str_q;
  assign res_o.height   = res_hgt_q;

  // stage b logic: gyro magnitude product and accel reciprocal products
  logic [15:0] gz_abs, ax_neg;
  logic [9:0]  n_x, n_y;
  logic [13:0] z_x, z_y;
  logic [27:0] p_x, p_y;
  logic [23:0] mag_b;

  always_comb begin
    gz_abs = a_gz_q[15] ? (~a_gz_q + 16'd1) : a_gz_q;
    mag_b  = 24'(gz_abs) * 24'(period_q);
    ax_neg = ~a_ax_q + 16'd1;
    n_x    = ax_neg[9:0];
    n_y    = a_ay_q[9:0];
    // ceil(10n/33) and ceil(5n/33) as floor((k*n + 32) / 33)
    z_x    = {1'b0, n_x, 3'b000} + {3'b000, n_x, 1'b0} + 14'd32;
    z_y    = {2'b00, n_y, 2'b00} + {4'b0000, n_y} + 14'd32;
    p_x    = 28'(z_x) * 28'(imap_pkg::Recip33);
    p_y    = 28'(z_y) * 28'(imap_pkg::Recip33);
  end

  // stage c logic: step = mag + floor(3 mag / 125), positions clamped
  logic [24:0]        z3;
  logic [50:0]        p3;
  logic [18:0]        q3;
  imap_pkg::stretch_t str_c;
  imap_pkg::height_t  hgt_c;

  always_comb begin
    z3 = {b_mag_q, 1'b0} + {1'b0, b_mag_q};
    p3 = 51'(z3) * 51'(imap_pkg::Recip125);
    q3 = p3[50:32];
    if (b_x_top_q) begin
      str_c = imap_pkg::StretchHi;
    end else if (b_x_far_q || b_qx_q > imap_pkg::StretchCut) begin
      str_c = imap_pkg::StretchLo;
    end else begin
      str_c = imap_pkg::StretchHi - b_qx_q;
    end
    if (b_y_top_q) begin
      hgt_c = imap_pkg::HeightHi;
    end else if (b_y_far_q || b_qy_q > imap_pkg::HeightCut) begin
      hgt_c = imap_pkg::HeightLo;
    end else begin
      hgt_c = imap_pkg::HeightHi - b_qy_q[7:0];
    end
  end

  // stage d logic: angle integration, accumulators, decimation
  logic signed [25:0] ang_sum;
  imap_pkg::angle_t   ang_clamp;
  logic [11:0]        s_add;
  logic [10:0]        s_sat;
  logic [10:0]        h_add;
  logic [9:0]         h_sat;
  logic [22:0]        s_prod;
  logic [21:0]        h_prod;
  imap_pkg::count_t   count_inc;

  always_comb begin
    ang_sum = c_neg_q ? (26'(angle_q) - 26'(c_step_q)) : (26'(angle_q) + 26'(c_step_q));
    if (ang_sum < 26'sd0) begin
      ang_clamp = '0;
    end else if (ang_sum > 26'(imap_pkg::AngleMax)) begin
      ang_clamp = imap_pkg::AngleMax;
    end else begin
      ang_clamp = ang_sum[17:0];
    end
    angle_d = c_en_q ? ang_clamp : angle_q;

    s_add  = 12'(ssum_q) + 12'(c_stretch_q);
    s_sat  = s_add[11] ? imap_pkg::StretchSumMax : s_add[10:0];
    h_add  = 11'(hsum_q) + 11'(c_height_q);
    h_sat  = h_add[10] ? imap_pkg::HeightSumMax : h_add[9:0];
    s_prod = 23'(s_sat) * 23'(imap_pkg::Recip6);
    h_prod = 22'(h_sat) * 22'(imap_pkg::Recip6);

    count_inc = count_q + 1'b1;
    emit      = count_inc == imap_pkg::CountLast;
    if (emit) begin
      ssum_d  = 11'(s_prod[22:14]);
      hsum_d  = 10'(h_prod[21:14]);
      count_d = '0;
    end else begin
      ssum_d  = s_sat;
      hsum_d  = h_sat;
      count_d = count_inc;
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= imap_pkg::PeriodReset;
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      res_valid_q <= 1'b0;
      angle_q     <= imap_pkg::AngleReset;
      ssum_q      <= '0;
      hsum_q      <= '0;
      count_q     <= '0;
    end else begin
      if (cfg_i.valid) begin
        period_q <= cfg_i.sample_period_ms;
      end
      a_valid_q   <= acc || (a_valid_q && !adv_a);
      b_valid_q   <= adv_a || (b_valid_q && !adv_b);
      c_valid_q   <= adv_b || (c_valid_q && !fire_d);
      res_valid_q <= (fire_d && emit) || (res_valid_q && !res_o.ready);
      if (fire_d) begin
        angle_q <= angle_d;
        ssum_q  <= ssum_d;
        hsum_q  <= hsum_d;
        count_q <= count_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (acc) begin
      a_ax_q <= req_i.accel_x;
      a_ay_q <= req_i.accel_y;
      a_gz_q <= req_i.gyro_z;
    end
    if (adv_a) begin
      b_mag_q   <= mag_b;
      b_neg_q   <= a_gz_q[15];
      b_x_top_q <= !a_ax_q[15];
      b_x_far_q <= a_ax_q < imap_pkg::AxFar;
      b_qx_q    <= p_x[27:19];
      b_y_top_q <= !(a_ay_q > 16'sd0);
      b_y_far_q <= a_ay_q > imap_pkg::AyFar;
      b_qy_q    <= p_y[27:19];
    end
    if (adv_b) begin
      c_step_q    <= b_mag_q + 24'(q3);
      c_neg_q     <= b_neg_q;
      c_en_q      <= b_mag_q >= imap_pkg::StepMin;
      c_stretch_q <= str_c;
      c_height_q  <= hgt_c;
    end
    if (fire_d && emit) begin
      res_rot_q <= angle_d[17:10];
      res_str_q <= s_prod[22:14];
      res_hgt_q <= h_prod[21:14];
    end
  end

endmodule

// ----- rtl/imap_checker.sv -----
// imap_checker.sv
// port-level assertions for imu_to_arm_position_mapper_core, bound into each instance of it
// depends on imap_pkg and imu_to_arm_position_mapper_core_defines.svh
`timescale 1ns / 1ps
`include "imu_to_arm_position_mapper_core_defines.svh"

module imap_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                res_valid_i,
  input logic                res_ready_i,
  input imap_pkg::rotation_t res_rotation_i,
  input imap_pkg::stretch_t  res_stretch_i,
  input imap_pkg::height_t   res_height_i
);

  // observed result payload and idle cycles
  logic [24:0] res_bits;
  logic        quiet;

  assign res_bits = {res_rotation_i, res_stretch_i, res_height_i};
  assign quiet    = !(req_valid_i && req_ready_i) && !res_valid_i;

  // a stalled result stays offered and unchanged
  `IMAP_ASSERT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i |=> res_valid_i)
  `IMAP_ASSERT_STABLE(a_res_stable, clk_i, rst_ni, res_valid_i && !res_ready_i, res_bits)

  // requests back up only behind a stalled result
  `IMAP_ASSERT(a_stall_src, clk_i, rst_ni, !req_ready_i |-> res_valid_i && !res_ready_i)

  // with no accepted requests and an empty result register the drained pipeline offers no result
  `IMAP_ASSERT(a_drain, clk_i, rst_ni, quiet ##1 quiet ##1 quiet ##1 quiet |=> !res_valid_i)

endmodule

bind imu_to_arm_position_mapper_core imap_checker u_imap_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .res_rotation_i (res_o.rotation),
  .res_stretch_i  (res_o.stretch),
  .res_height_i   (res_o.height)
);
